// File: src/sha1h_pkg.sv
// shared types, constants and state codes for the byte-stream sha-1 hasher
package sha1h_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int NUM_CV   = 5;
    localparam int NUM_WIN  = 16;
    localparam int ROUNDS   = 80;
    localparam int ROUND_W  = 7;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 61;
    localparam int LEN_IDX_W = 3;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;
    localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
    localparam logic [POS_W-1:0]   POS_LEN    = 6'd56;
    localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [ROUND_W-1:0] STAGE1_START = 7'd20;
    localparam logic [ROUND_W-1:0] STAGE2_START = 7'd40;
    localparam logic [ROUND_W-1:0] STAGE3_START = 7'd60;

    typedef logic [NUM_CV-1:0][WORD_W-1:0] chain_t;

    localparam chain_t H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [3:0][WORD_W-1:0] ROUND_K = {
        32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        length_error;
    } out_word_t;

    typedef struct packed {
        logic              init;
        logic              load;
        logic [BYTE_W-1:0] load_byte;
        logic              start;
    } cmd_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_ADD
    } cs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_HASH,
        ST_OUT
    } st_t;

endpackage

// File: src/sha1h_compress.sv
// block buffer, message schedule window and shared sha-1 round unit
module sha1h_compress (
    input  logic            clk,
    input  logic            rst_n,
    input  sha1h_pkg::cmd_t cmd,
    output logic            done,
    output sha1h_pkg::chain_t chain
);
    import sha1h_pkg::*;

    cs_t                 state_reg, state_next;
    logic [ROUND_W-1:0]  rnd_reg, rnd_next;
    chain_t              chain_reg;
    logic [WORD_W-1:0]   win_reg [NUM_WIN];
    logic [WORD_W-1:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WORD_W-1:0]   w_new;
    logic [WORD_W-1:0]   f_val;
    logic [WORD_W-1:0]   t_val;
    logic [1:0]          stage;

    assign chain = chain_reg;
    assign done  = (state_reg == CS_ADD);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = CS_ROUND;
                    rnd_next   = '0;
                end
            end
            CS_ROUND:
            begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = CS_ADD;
                end
            end
            CS_ADD:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (rnd_reg < STAGE1_START)
            stage = 2'd0;
        else if (rnd_reg < STAGE2_START)
            stage = 2'd1;
        else if (rnd_reg < STAGE3_START)
            stage = 2'd2;
        else
            stage = 2'd3;
    end

    always_comb
    begin
        unique case (stage)
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd2:    f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    logic [WORD_W-1:0] w_mix;
    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};
    assign t_val = {a_reg[WORD_W-6:0], a_reg[WORD_W-1:WORD_W-5]} + f_val + e_reg
                 + win_reg[0] + ROUND_K[stage];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            rnd_reg   <= '0;
            chain_reg <= H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            if (cmd.init)
            begin
                chain_reg <= H_INIT;
            end
            else if (state_reg == CS_ADD)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (state_reg == CS_ROUND)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[WORD_W-1:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // bytes shift in big-endian; rounds shift whole words
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < NUM_WIN - 1; i++)
            begin
                win_reg[i] <= {win_reg[i][WORD_W-BYTE_W-1:0],
                               win_reg[i+1][WORD_W-1:WORD_W-BYTE_W]};
            end
            win_reg[NUM_WIN-1] <= {win_reg[NUM_WIN-1][WORD_W-BYTE_W-1:0], cmd.load_byte};
        end
        else if (state_reg == CS_ROUND)
        begin
            for (int i = 0; i < NUM_WIN - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[NUM_WIN-1] <= w_new;
        end
    end

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> state_reg == CS_IDLE)
        else $error("start while compression busy");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == CS_IDLE)
        else $error("byte load during compression");
    a_add_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CS_ADD |-> $past(rnd_reg) == ROUND_LAST)
        else $error("chain update not after final round");
`endif

endmodule

// File: src/sha1_byte_stream_hasher.sv
// top level: byte intake, padding sequencer and digest output
//
// usage
// - input channel (in_valid / in_ready / in_data) takes one word per message byte;
//   byte_valid marks a real byte, end_of_message closes the message
// - output channel (out_valid / out_ready / out_data) gives five digest words,
//   word_index 0 to 4, last_word on the fifth, length_error if the bit count wrapped
// - one byte is taken per cycle; every 64th byte starts a compression that holds
//   in_ready low through its 80 rounds of the one round unit and the add
// - end of message: pad, zero and length bytes go in one per cycle outside compressions,
//   at most 72 bytes, with one or two compressions, then the five digest words
// - with a wrapped bit count no padding is done; five zero words with length_error follow
// - the output stays valid and held while out_ready is low; no new input is taken
//   until the fifth word is taken, then the hasher is ready for the next message
// - reset clears the sequencer, byte position, bit count and loads the initial chain
//   value; in_ready is high from reset on
module sha1_byte_stream_hasher (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sha1h_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sha1h_pkg::out_word_t out_data
);
    import sha1h_pkg::*;

    st_t                   state_reg, state_next;
    st_t                   ret_reg, ret_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic                  pad_first_reg, pad_first_next;
    logic [LEN_IDX_W-1:0]  len_idx_reg, len_idx_next;
    logic [IDX_W-1:0]      widx_reg, widx_next;
    cmd_t                  cmd;
    logic                  done;
    chain_t                chain;
    logic [63:0]           bit_len;
    logic                  take;
    logic                  wrap;

    sha1h_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .done  (done),
        .chain (chain)
    );

    assign bit_len = {cnt_reg, 3'b000};
    assign take    = in_data.byte_valid && !ovf_reg;
    assign wrap    = take && (&cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        pad_first_next = pad_first_reg;
        len_idx_next   = len_idx_reg;
        widx_next      = widx_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        out_data.digest_word  = ovf_reg ? '0 : chain[widx_reg];
        out_data.word_index   = widx_reg;
        out_data.last_word    = (widx_reg == LAST_IDX);
        out_data.length_error = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    pad_first_next = 1'b1;
                    if (take)
                    begin
                        cnt_next = cnt_reg + 61'd1;
                    end
                    if (wrap)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (take && !wrap)
                    begin
                        cmd.load      = 1'b1;
                        cmd.load_byte = in_data.data_byte;
                        pos_next      = pos_reg + 6'd1;
                    end
                    priority if (in_data.end_of_message && (ovf_reg || wrap))
                    begin
                        state_next = ST_OUT;
                        widx_next  = '0;
                    end
                    else if (take && pos_reg == POS_LAST)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_HASH;
                        ret_next   = in_data.end_of_message ? ST_PAD : ST_IDLE;
                    end
                    else if (in_data.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (!pad_first_reg && pos_reg == POS_LEN)
                begin
                    state_next   = ST_LEN;
                    len_idx_next = '0;
                end
                else
                begin
                    cmd.load       = 1'b1;
                    cmd.load_byte  = pad_first_reg ? PAD_BYTE : '0;
                    pad_first_next = 1'b0;
                    pos_next       = pos_reg + 6'd1;
                    if (pos_reg == POS_LAST)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_HASH;
                        ret_next   = ST_PAD;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.load      = 1'b1;
                cmd.load_byte = bit_len[(3'd7 - len_idx_reg) * 8 +: 8];
                pos_next      = pos_reg + 6'd1;
                len_idx_next  = len_idx_reg + 3'd1;
                if (pos_reg == POS_LAST)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_HASH;
                    ret_next   = ST_OUT;
                    widx_next  = '0;
                end
            end
            ST_HASH:
            begin
                if (done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (widx_reg == LAST_IDX)
                    begin
                        cmd.init   = 1'b1;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        pos_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        widx_next = widx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            len_idx_reg   <= '0;
            widx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            pad_first_reg <= pad_first_next;
            len_idx_reg   <= len_idx_next;
            widx_reg      <= widx_next;
        end
    end

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while digest pending");
    a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEN |-> pos_reg == {3'b111, len_idx_reg})
        else $error("length bytes misplaced in block");
    a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !ovf_reg) |-> pos_reg == '0)
        else $error("digest emitted with partial block");
    a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> widx_reg <= LAST_IDX)
        else $error("digest word index out of range");
`endif

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the byte-stream sha-1 hasher
`timescale 1ns / 1ps

module tb;
    import sha1h_pkg::*;

    class digest_tracker;
        out_word_t   expected_digest_words[$];
        logic [31:0] chain[NUM_CV];
        logic [31:0] blk[NUM_WIN];
        logic [5:0]  pos;
        logic [63:0] bits;
        bit          ovf;
        int          errors;
        int          words_checked;

        function new();
            errors = 0;
            words_checked = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < NUM_CV; i++)
                chain[i] = H_INIT[i];
            for (int i = 0; i < NUM_WIN; i++)
                blk[i] = '0;
            pos = '0;
            bits = '0;
            ovf = 1'b0;
        endfunction

        function void run_rounds();
            logic [31:0] w[NUM_WIN];
            logic [31:0] a, b, c, d, e, f, k, x, sum;
            for (int t = 0; t < NUM_WIN; t++)
                w[t] = blk[t];
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int t = 0; t < ROUNDS; t++)
            begin
                if (t >= 16)
                begin
                    x = w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15];
                    x = {x[30:0], x[31]};
                    w[t & 15] = x;
                end
                else
                    x = w[t];
                if (t < 20)
                    f = (b & c) | (~b & d);
                else if (t >= 40 && t < 60)
                    f = (b & c) | (b & d) | (c & d);
                else
                    f = b ^ c ^ d;
                k = ROUND_K[t / 20];
                sum = {a[26:0], a[31:27]} + f + e + x + k;
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = sum;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
            for (int i = 0; i < NUM_WIN; i++)
                blk[i] = '0;
            pos = '0;
        endfunction

        function void put_byte(logic [7:0] v);
            int sh;
            sh = 24 - 8 * int'(pos[1:0]);
            blk[pos[5:2]] |= 32'(v) << sh;
            if (pos == POS_LAST)
                run_rounds();
            else
                pos = pos + 6'd1;
        endfunction

        function void close_message();
            int sh;
            sh = 24 - 8 * int'(pos[1:0]);
            blk[pos[5:2]] |= 32'(PAD_BYTE) << sh;
            if (pos >= POS_LEN)
                run_rounds();
            blk[14] = bits[63:32];
            blk[15] = bits[31:0];
            run_rounds();
        endfunction

        function void take_byte_word(in_word_t w);
            out_word_t o;
            bit err;
            if (w.byte_valid && !ovf)
            begin
                bits = bits + 64'd8;
                if (bits < 64'd8)
                    ovf = 1'b1;
                else
                    put_byte(w.data_byte);
            end
            if (!w.end_of_message)
                return;
            err = ovf;
            if (!err)
                close_message();
            for (int i = 0; i < NUM_CV; i++)
            begin
                o.digest_word  = err ? 32'd0 : chain[i];
                o.word_index   = IDX_W'(i);
                o.last_word    = (IDX_W'(i) == LAST_IDX);
                o.length_error = err;
                expected_digest_words.push_back(o);
            end
            restart();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
            errors++;
        endtask

        task check_digest_word(out_word_t got);
            out_word_t want;
            words_checked++;
            if (expected_digest_words.size() == 0)
            begin
                report("unexpected digest word", got.digest_word, 32'd0);
                return;
            end
            want = expected_digest_words.pop_front();
            if (got.digest_word !== want.digest_word)
                report("digest_word", got.digest_word, want.digest_word);
            if (got.word_index !== want.word_index)
                report("word_index", 32'(got.word_index), 32'(want.word_index));
            if (got.last_word !== want.last_word)
                report("last_word", 32'(got.last_word), 32'(want.last_word));
            if (got.length_error !== want.length_error)
                report("length_error", 32'(got.length_error), 32'(want.length_error));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    digest_tracker tracker;
    bit            calm;
    int            items_sent;

    sha1_byte_stream_hasher u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic in_word_t make_word(logic [7:0] d, bit v, bit e);
        in_word_t w;
        w.data_byte      = d;
        w.byte_valid     = v;
        w.end_of_message = e;
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_byte_word(w);
        if (w.byte_valid || w.end_of_message)
            items_sent++;
    endtask

    task automatic send_message(input int len, input bit split_end);
        bit last;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            last = (i == len - 1) && !split_end;
            send_word(make_word(8'($urandom_range(0, 255)), 1'b1, last));
        end
        if (split_end || len == 0)
            send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    endtask

    // receiver: random stalls, one long hold while a digest is pending
    initial
    begin
        int stall;
        bit held;
        stall = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && tracker.words_checked >= 30 && out_valid && !out_data.last_word)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (700) @(posedge clk);
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            tracker.check_digest_word(out_data);

    initial
    begin
        int boundary_len[10];
        int len;
        int r;
        int msgs;
        boundary_len = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
        tracker = new();
        calm = 1'b0;
        items_sent = 0;
        msgs = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle words, empty message, short messages with both ways of ending
        send_word(make_word(8'hFF, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b0));
        send_word(make_word(8'hFF, 1'b0, 1'b1));
        send_word(make_word(8'h61, 1'b1, 1'b0));
        send_word(make_word(8'h62, 1'b1, 1'b0));
        send_word(make_word(8'h63, 1'b1, 1'b1));
        send_word(make_word(8'hFF, 1'b1, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b1));
        send_word(make_word(8'h00, 1'b1, 1'b1));
        send_word(make_word(8'hA5, 1'b1, 1'b0));
        send_word(make_word(8'h5A, 1'b1, 1'b1));

        while (items_sent < 500 || msgs < 12)
        begin
            calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 20)
                len = boundary_len[$urandom_range(0, 9)];
            else if (r < 70)
                len = $urandom_range(0, 40);
            else
                len = $urandom_range(41, 150);
            send_message(len, $urandom_range(0, 99) < 30);
            msgs++;
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_digest_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: sha1_byte_stream_hasher.f
src/sha1h_pkg.sv
src/sha1h_compress.sv
src/sha1_byte_stream_hasher.sv
tb/sv/tb.sv
